// ===== rtl/g2e_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// g2e_pkg
// shared types, constants and elaboration-time functions for the
// geodetic to earth-centred conversion pipeline
// ----------------------------------------------------------------------------
package g2e_pkg;

    localparam int ANGLE_BITS      = 32;
    localparam int TRIG_ITERATIONS = 32;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 48;
    localparam int SEMI_W     = 33;
    localparam int ECC_W      = 48;
    localparam int OUT_W      = 35;

    localparam logic [CFG_IDX_W-1:0] REG_SEMI_MAJOR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ECC_SQ     = 1'b1;

    localparam logic [SEMI_W-1:0] SEMI_RESET = 33'd6378137000;
    localparam logic [ECC_W-1:0]  ECC_RESET  = 48'd1884300454589;

    localparam logic [63:0] PI_Q61   = 64'h6487ED5110B4611A;
    localparam logic [63:0] GAIN_Q60 = 64'd700114967507363238;
    localparam logic [60:0] ONE_Q60  = 61'd1 << 60;
    localparam logic [56:0] RN_MAX   = 57'd1 << 56;

    localparam logic signed [63:0] OUT_MAX = 64'sd17179869183;
    localparam logic signed [63:0] OUT_MIN = -64'sd17179869184;

    // sqrt of a 122-bit radicand, two bits a step; division over 109 numerator bits
    localparam int SQ_STEPS  = 61;
    localparam int DIV_STEPS = SEMI_W + 76;

    // pipeline stage numbers (register count after the input)
    localparam int S_Z    = 4;
    localparam int S_TRIG = S_Z + TRIG_ITERATIONS + 1;
    localparam int S_W    = S_TRIG + 6;
    localparam int S_RN   = S_W + SQ_STEPS + DIV_STEPS + 1;
    localparam int S_P    = S_RN + 1;
    localparam int S_Q    = S_P + 3;
    localparam int S_OUT  = S_Q + 3;
    localparam int LATENCY = S_OUT;

    typedef struct packed {
        logic signed [31:0] h;
        logic [1:0]         qlat;
        logic [1:0]         qlon;
        logic               nlat;
        logic               nlon;
    } t_side;

    typedef struct packed {
        logic signed [31:0] h;
        logic signed [63:0] slat;
        logic signed [63:0] clat;
        logic signed [63:0] slon;
        logic signed [63:0] clon;
    } t_trig;

    // 2^e / d by long division
    function automatic logic [63:0] pow2_div(input int e, input int d);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 62; b >= 0; b--) begin
            rem = {rem[62:0], (b == e)};
            quo = {quo[62:0], 1'b0};
            if (rem >= 64'(d)) begin
                rem = rem - 64'(d);
                quo[0] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [63:0] atan_q60(input int idx);
        logic [63:0] sum;
        int sh;
        sum = '0;
        if (idx == 0) begin
            sum = PI_Q61 >> 3;
        end else begin
            for (int k = 0; k < 32; k++) begin
                sh = idx * (2 * k + 1);
                if (sh <= 60) begin
                    if (k % 2 == 1) sum = sum - pow2_div(60 - sh, 2 * k + 1);
                    else            sum = sum + pow2_div(60 - sh, 2 * k + 1);
                end
            end
        end
        return sum;
    endfunction

endpackage

// ===== rtl/g2e_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// g2e_mul
// two-stage 64x64 unsigned multiplier: four 32x32 partials, then the sum
// ----------------------------------------------------------------------------
module g2e_mul (
    input  logic         i_clk,
    input  logic [63:0]  i_a,
    input  logic [63:0]  i_b,
    output logic [127:0] o_p
);

    logic [63:0]  r_ll, r_lh, r_hl, r_hh;
    logic [127:0] r_p;

    always_ff @(posedge i_clk) begin
        r_ll <= i_a[31:0]  * i_b[31:0];
        r_lh <= i_a[31:0]  * i_b[63:32];
        r_hl <= i_a[63:32] * i_b[31:0];
        r_hh <= i_a[63:32] * i_b[63:32];
        r_p  <= {64'd0, r_ll} + {32'd0, r_lh, 32'd0} + {32'd0, r_hl, 32'd0}
              + {r_hh, 64'd0};
    end

    assign o_p = r_p;

endmodule

// ===== rtl/g2e_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// g2e_cordic
// unrolled rotation-mode cordic, one register stage per iteration
// ----------------------------------------------------------------------------
module g2e_cordic (
    input  logic               i_clk,
    input  logic signed [63:0] i_z,
    output logic signed [63:0] o_x,
    output logic signed [63:0] o_y
);

    localparam int N = g2e_pkg::TRIG_ITERATIONS;

    logic signed [63:0] r_x [N];
    logic signed [63:0] r_y [N];
    logic signed [63:0] r_z [N];

    for (genvar i = 0; i < N; i++) begin : g_stage
        localparam logic signed [63:0] ATAN = g2e_pkg::atan_q60(i);
        logic signed [63:0] x_in, y_in, z_in;
        if (i == 0) begin : g_first
            assign x_in = g2e_pkg::GAIN_Q60;
            assign y_in = '0;
            assign z_in = i_z;
        end else begin : g_next
            assign x_in = r_x[i-1];
            assign y_in = r_y[i-1];
            assign z_in = r_z[i-1];
        end
        always_ff @(posedge i_clk) begin
            if (!z_in[63]) begin
                r_x[i] <= x_in - (y_in >>> i);
                r_y[i] <= y_in + (x_in >>> i);
                r_z[i] <= z_in - ATAN;
            end else begin
                r_x[i] <= x_in + (y_in >>> i);
                r_y[i] <= y_in - (x_in >>> i);
                r_z[i] <= z_in + ATAN;
            end
        end
    end

    assign o_x = r_x[N-1];
    assign o_y = r_y[N-1];

endmodule

// ===== rtl/geodetic_to_ecef.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geodetic_to_ecef
// latitude, longitude and height to earth-centred x, y, z in millimetres
// ----------------------------------------------------------------------------
// channel   direction  handshake                    payload
// input     in         i_start && !o_busy           i_latitude i_longitude i_height_mm
// result    out        o_valid strobe, one cycle    o_x_mm o_y_mm o_z_mm
// config    in         i_cfg_valid && o_cfg_ready   i_cfg_index i_cfg_data
//
// one item per cycle; results come out in the order their items went in
// main stages: cordic (32 stages), floor square root (61 stages, two bits each)
// and the radius division (109 stages, one quotient bit each)
// synchronous active-low reset clears the valid line and loads wgs-84
// o_busy stays low; the result strobe cannot be held off
// ----------------------------------------------------------------------------
module geodetic_to_ecef (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    output logic                                 o_busy,
    input  logic signed [31:0]                   i_latitude,
    input  logic signed [31:0]                   i_longitude,
    input  logic signed [31:0]                   i_height_mm,
    output logic                                 o_valid,
    output logic signed [g2e_pkg::OUT_W-1:0]     o_x_mm,
    output logic signed [g2e_pkg::OUT_W-1:0]     o_y_mm,
    output logic signed [g2e_pkg::OUT_W-1:0]     o_z_mm,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [g2e_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [g2e_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int AB     = g2e_pkg::ANGLE_BITS;
    localparam int S_Z    = g2e_pkg::S_Z;
    localparam int S_TRIG = g2e_pkg::S_TRIG;
    localparam int S_W    = g2e_pkg::S_W;
    localparam int S_RN   = g2e_pkg::S_RN;
    localparam int S_P    = g2e_pkg::S_P;
    localparam int S_Q    = g2e_pkg::S_Q;
    localparam int S_OUT  = g2e_pkg::S_OUT;
    localparam int SQN    = g2e_pkg::SQ_STEPS;
    localparam int DVN    = g2e_pkg::DIV_STEPS;
    localparam int SW     = g2e_pkg::SEMI_W;

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [g2e_pkg::OUT_W-1:0] to_mm(input logic [63:0] m,
                                                       input logic neg);
        logic signed [63:0] v;
        logic signed [63:0] t;
        v = neg ? -$signed(m) : $signed(m);
        t = (v + 64'sd32768) >>> 16;
        if (t > g2e_pkg::OUT_MAX) t = g2e_pkg::OUT_MAX;
        if (t < g2e_pkg::OUT_MIN) t = g2e_pkg::OUT_MIN;
        return t[g2e_pkg::OUT_W-1:0];
    endfunction

    // configuration
    logic [SW-1:0]               r_semi;
    logic [g2e_pkg::ECC_W-1:0]   r_ecc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_semi <= g2e_pkg::SEMI_RESET;
            r_ecc  <= g2e_pkg::ECC_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                g2e_pkg::REG_SEMI_MAJOR: r_semi <= i_cfg_data[SW-1:0];
                g2e_pkg::REG_ECC_SQ:     r_ecc  <= i_cfg_data[g2e_pkg::ECC_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_busy      = 1'b0;

    // valid line
    logic r_vld [1:S_OUT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= S_OUT; k++) r_vld[k] <= 1'b0;
        end else begin
            r_vld[1] <= i_start;
            for (int k = 2; k <= S_OUT; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // angle reduction
    logic [39:0]    lat_ext, lon_ext;
    logic [AB-1:0]  lat_r, lon_r;
    logic [AB-3:0]  lat_lo, lon_lo;
    localparam logic [AB-3:0] HALF = (AB-2)'(1) << (AB - 3);

    assign lat_ext = {i_latitude, 8'd0};
    assign lon_ext = {i_longitude, 8'd0};
    assign lat_r   = lat_ext[39 -: AB] + (AB'(1) << (AB - 3));
    assign lon_r   = lon_ext[39 -: AB] + (AB'(1) << (AB - 3));
    assign lat_lo  = lat_r[AB-3:0];
    assign lon_lo  = lon_r[AB-3:0];

    g2e_pkg::t_side r_side [1:S_TRIG-1];
    logic [63:0]    r_mag_lat, r_mag_lon;

    always_ff @(posedge i_clk) begin
        r_side[1].h    <= i_height_mm;
        r_side[1].qlat <= lat_r[AB-1:AB-2];
        r_side[1].qlon <= lon_r[AB-1:AB-2];
        r_side[1].nlat <= lat_lo < HALF;
        r_side[1].nlon <= lon_lo < HALF;
        r_mag_lat <= 64'((lat_lo < HALF) ? HALF - lat_lo : lat_lo - HALF);
        r_mag_lon <= 64'((lon_lo < HALF) ? HALF - lon_lo : lon_lo - HALF);
        for (int k = 2; k < S_TRIG; k++) r_side[k] <= r_side[k-1];
    end

    logic [127:0] pz_lat, pz_lon;

    g2e_mul u_mul_zlat (.i_clk(i_clk), .i_a(r_mag_lat), .i_b(g2e_pkg::PI_Q61),
                        .o_p(pz_lat));
    g2e_mul u_mul_zlon (.i_clk(i_clk), .i_a(r_mag_lon), .i_b(g2e_pkg::PI_Q61),
                        .o_p(pz_lon));

    logic signed [63:0] r_z_lat, r_z_lon;

    always_ff @(posedge i_clk) begin
        r_z_lat <= r_side[S_Z-1].nlat ? -$signed(pz_lat[AB +: 64])
                                      : $signed(pz_lat[AB +: 64]);
        r_z_lon <= r_side[S_Z-1].nlon ? -$signed(pz_lon[AB +: 64])
                                      : $signed(pz_lon[AB +: 64]);
    end

    logic signed [63:0] x_lat, y_lat, x_lon, y_lon;

    g2e_cordic u_cordic_lat (.i_clk(i_clk), .i_z(r_z_lat), .o_x(x_lat), .o_y(y_lat));
    g2e_cordic u_cordic_lon (.i_clk(i_clk), .i_z(r_z_lon), .o_x(x_lon), .o_y(y_lon));

    // quadrant map and trig line
    g2e_pkg::t_trig r_trig [S_TRIG:S_Q];

    always_ff @(posedge i_clk) begin
        r_trig[S_TRIG].h <= r_side[S_TRIG-1].h;
        case (r_side[S_TRIG-1].qlat)
            2'd0: begin r_trig[S_TRIG].clat <= x_lat;  r_trig[S_TRIG].slat <= y_lat;  end
            2'd1: begin r_trig[S_TRIG].clat <= -y_lat; r_trig[S_TRIG].slat <= x_lat;  end
            2'd2: begin r_trig[S_TRIG].clat <= -x_lat; r_trig[S_TRIG].slat <= -y_lat; end
            default: begin
                r_trig[S_TRIG].clat <= y_lat;
                r_trig[S_TRIG].slat <= -x_lat;
            end
        endcase
        case (r_side[S_TRIG-1].qlon)
            2'd0: begin r_trig[S_TRIG].clon <= x_lon;  r_trig[S_TRIG].slon <= y_lon;  end
            2'd1: begin r_trig[S_TRIG].clon <= -y_lon; r_trig[S_TRIG].slon <= x_lon;  end
            2'd2: begin r_trig[S_TRIG].clon <= -x_lon; r_trig[S_TRIG].slon <= -y_lon; end
            default: begin
                r_trig[S_TRIG].clon <= y_lon;
                r_trig[S_TRIG].slon <= -x_lon;
            end
        endcase
        for (int k = S_TRIG + 1; k <= S_Q; k++) r_trig[k] <= r_trig[k-1];
    end

    // sin^2 and the radicand
    logic [127:0] p_s2, p_es2;
    logic [60:0]  r_s2;
    logic [60:0]  r_w;

    g2e_mul u_mul_s2 (.i_clk(i_clk), .i_a(mag64(r_trig[S_TRIG].slat)),
                      .i_b(mag64(r_trig[S_TRIG].slat)), .o_p(p_s2));

    always_ff @(posedge i_clk) begin
        r_s2 <= (p_s2[127:60] > 68'(g2e_pkg::ONE_Q60)) ? g2e_pkg::ONE_Q60
                                                      : p_s2[120:60];
        r_w  <= g2e_pkg::ONE_Q60 - p_es2[108:48];
    end

    g2e_mul u_mul_es2 (.i_clk(i_clk), .i_a(64'(r_ecc)), .i_b(64'(r_s2)), .o_p(p_es2));

    // floor square root of w * 2^60
    logic [63:0] r_sq_rem  [SQN];
    logic [60:0] r_sq_root [SQN];
    logic [60:0] r_sq_w    [SQN];

    for (genvar j = 0; j < SQN; j++) begin : g_sqrt
        localparam int P = SQN - 1 - j;
        logic [63:0]  rem_in, rem2, trial;
        logic [60:0]  root_in, w_in;
        logic [121:0] rad;
        if (j == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign w_in    = r_w;
        end else begin : g_next
            assign rem_in  = r_sq_rem[j-1];
            assign root_in = r_sq_root[j-1];
            assign w_in    = r_sq_w[j-1];
        end
        assign rad   = {1'b0, w_in, 60'd0};
        assign rem2  = {rem_in[61:0], rad[2*P+1 -: 2]};
        assign trial = {1'b0, root_in, 2'b01};
        always_ff @(posedge i_clk) begin
            r_sq_w[j] <= w_in;
            if (rem2 >= trial) begin
                r_sq_rem[j]  <= rem2 - trial;
                r_sq_root[j] <= {root_in[59:0], 1'b1};
            end else begin
                r_sq_rem[j]  <= rem2;
                r_sq_root[j] <= {root_in[59:0], 1'b0};
            end
        end
    end

    // rn = a * 2^76 / root, one quotient bit a stage
    logic [61:0] r_dv_rem  [DVN];
    logic [57:0] r_dv_q    [DVN];
    logic        r_dv_ovf  [DVN];
    logic [60:0] r_dv_root [DVN];

    for (genvar j = 0; j < DVN; j++) begin : g_div
        logic [61:0] rem_in, rem2;
        logic [57:0] q_in;
        logic        ovf_in, nbit;
        logic [60:0] root_in;
        if (j == 0) begin : g_first
            assign rem_in  = '0;
            assign q_in    = '0;
            assign ovf_in  = 1'b0;
            assign root_in = r_sq_root[SQN-1];
        end else begin : g_next
            assign rem_in  = r_dv_rem[j-1];
            assign q_in    = r_dv_q[j-1];
            assign ovf_in  = r_dv_ovf[j-1];
            assign root_in = r_dv_root[j-1];
        end
        if (j < SW) begin : g_abit
            assign nbit = r_semi[SW-1-j];
        end else begin : g_zbit
            assign nbit = 1'b0;
        end
        assign rem2 = {rem_in[60:0], nbit};
        always_ff @(posedge i_clk) begin
            r_dv_root[j] <= root_in;
            r_dv_ovf[j]  <= ovf_in | q_in[57];
            if (rem2 >= {1'b0, root_in}) begin
                r_dv_rem[j] <= rem2 - {1'b0, root_in};
                r_dv_q[j]   <= {q_in[56:0], 1'b1};
            end else begin
                r_dv_rem[j] <= rem2;
                r_dv_q[j]   <= {q_in[56:0], 1'b0};
            end
        end
    end

    logic [56:0] r_rn;

    always_ff @(posedge i_clk) begin
        if (r_dv_ovf[DVN-1] || (r_dv_q[DVN-1] > 58'(g2e_pkg::RN_MAX))
                || (r_dv_root[DVN-1] == '0)) begin
            r_rn <= g2e_pkg::RN_MAX;
        end else begin
            r_rn <= r_dv_q[DVN-1][56:0];
        end
    end

    // rn + h, and the polar radius term
    logic signed [63:0] rnh;
    logic [56:0]        r_rn_p;
    logic [63:0]        r_rnh_mag;
    logic [48:0]        r_e2c;
    logic               r_pneg, r_pneg_d1, r_pneg_d2;

    assign rnh = $signed({7'd0, r_rn}) + $signed({{16{r_trig[S_RN].h[31]}},
                                                  r_trig[S_RN].h, 16'd0});

    always_ff @(posedge i_clk) begin
        r_rn_p    <= r_rn;
        r_rnh_mag <= mag64(rnh);
        r_e2c     <= (49'd1 << 48) - {1'b0, r_ecc};
        r_pneg    <= rnh[63] ^ r_trig[S_RN].clat[63];
        r_pneg_d1 <= r_pneg;
        r_pneg_d2 <= r_pneg_d1;
    end

    logic [127:0] p_rz, p_p;

    g2e_mul u_mul_rz (.i_clk(i_clk), .i_a(64'(r_rn_p)), .i_b(64'(r_e2c)), .o_p(p_rz));
    g2e_mul u_mul_p  (.i_clk(i_clk), .i_a(r_rnh_mag), .i_b(mag64(r_trig[S_P].clat)),
                      .o_p(p_p));

    logic signed [63:0] rzh;
    logic [63:0]        r_p_mag, r_rzh_mag;
    logic [2:0]         r_sg, r_sg_d1, r_sg_d2;

    assign rzh = $signed(p_rz[48 +: 64]) + $signed({{16{r_trig[S_Q-1].h[31]}},
                                                   r_trig[S_Q-1].h, 16'd0});

    always_ff @(posedge i_clk) begin
        r_p_mag   <= p_p[60 +: 64];
        r_rzh_mag <= mag64(rzh);
        r_sg      <= {rzh[63] ^ r_trig[S_Q-1].slat[63],
                      r_pneg_d2 ^ r_trig[S_Q-1].slon[63],
                      r_pneg_d2 ^ r_trig[S_Q-1].clon[63]};
        r_sg_d1   <= r_sg;
        r_sg_d2   <= r_sg_d1;
    end

    logic [127:0] p_x, p_y, p_z;

    g2e_mul u_mul_x (.i_clk(i_clk), .i_a(r_p_mag), .i_b(mag64(r_trig[S_Q].clon)),
                     .o_p(p_x));
    g2e_mul u_mul_y (.i_clk(i_clk), .i_a(r_p_mag), .i_b(mag64(r_trig[S_Q].slon)),
                     .o_p(p_y));
    g2e_mul u_mul_z (.i_clk(i_clk), .i_a(r_rzh_mag), .i_b(mag64(r_trig[S_Q].slat)),
                     .o_p(p_z));

    // rounding and saturation
    logic signed [g2e_pkg::OUT_W-1:0] r_x, r_y, r_z;

    always_ff @(posedge i_clk) begin
        r_x <= to_mm(p_x[60 +: 64], r_sg_d2[0]);
        r_y <= to_mm(p_y[60 +: 64], r_sg_d2[1]);
        r_z <= to_mm(p_z[60 +: 64], r_sg_d2[2]);
    end

    assign o_valid = r_vld[S_OUT];
    assign o_x_mm  = r_x;
    assign o_y_mm  = r_y;
    assign o_z_mm  = r_z;

endmodule

// ===== rtl/g2e_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// g2e_checker
// port-level checks on item timing of the conversion pipeline
// ----------------------------------------------------------------------------
module g2e_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic                              o_busy,
    input  logic                              o_valid,
    input  logic                              i_cfg_valid,
    input  logic                              o_cfg_ready
);

    // every accepted item gives a result after the fixed latency
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##(g2e_pkg::LATENCY) o_valid)
        else $error("accepted item produced no result");

    // no result without an item
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_start && !o_busy) |-> ##(g2e_pkg::LATENCY) !o_valid)
        else $error("result without an accepted item");

    // reset flushes the pipeline
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

    // the pipeline never refuses a register write, nor an item offered with it
    a_always_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> (o_cfg_ready && !o_busy))
        else $error("port refused a handshake");

endmodule

bind geodetic_to_ecef g2e_checker u_g2e_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .o_valid     (o_valid),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready)
);
